>>> hw/rtl/msd_pkg.sv
// Package for the multiplexed seven-segment display driver: shared types,
// register map, reset values and the digit-to-segment decoder.
// No dependencies; compiled first.
`default_nettype none

package msd_pkg;

    localparam int MAX_POSITIONS_DEF = 8;
    localparam int VALUE_BITS_DEF    = 31;

    localparam int RADIX_W = 5;
    localparam int POS_W   = 4;
    localparam int DIGIT_W = 4;
    localparam int SEG_W   = 7;
    localparam int SCAN_W  = 3;

    // Configuration port: four 32-bit registers at byte addresses 0, 4, 8 and 12.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_RADIX          = 2'd0,
        REG_POSITIONS_USED = 2'd1,
        REG_RIGHT_ALIGNED  = 2'd2,
        REG_SHOW_ZEROES    = 2'd3
    } reg_idx_t;

    localparam logic [RADIX_W-1:0] RADIX_RST     = 5'd10;
    localparam logic [POS_W-1:0]   POSITIONS_RST = 4'd4;
    localparam logic               RIGHT_RST     = 1'b1;
    localparam logic               ZEROES_RST    = 1'b0;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_SHOW
    } state_t;

    // Control from the sequencer to the serial divider.
    typedef struct packed {
        logic               start;
        logic [RADIX_W-1:0] divisor;
    } div_ctrl_t;

    // Segment enables, bit 0 = a through bit 6 = g. Digits above nine are blank.
    function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/msd_if.sv
// Valid/ready channel interfaces for the display driver: the number input
// and the segment/position output. Depends on msd_pkg.
`default_nettype none

interface msd_value_if #(
    parameter int VALUE_BITS = msd_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface msd_disp_if;
    logic                         valid;
    logic                         ready;
    logic [msd_pkg::SEG_W-1:0]    segments;
    logic [msd_pkg::SCAN_W-1:0]   position;

    modport source (output valid, output segments, output position, input ready);
    modport sink   (input valid, input segments, input position, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/msd_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, a small divisor.
// Used once per digit by the display driver. Depends on msd_pkg.
`default_nettype none

module msd_div #(
    parameter int VALUE_BITS = msd_pkg::VALUE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire msd_pkg::div_ctrl_t             ctrl,
    input  wire logic [VALUE_BITS-1:0]          dividend,
    output logic                                done,
    output logic [VALUE_BITS-1:0]               quotient,
    output logic [msd_pkg::RADIX_W-1:0]         remainder
);

    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam int RW    = msd_pkg::RADIX_W;

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic [RW-1:0]         div_reg;
    logic [RW:0]           shifted;
    logic                  fits;
    logic                  last;

    assign last = (cnt_reg == CNT_W'(VALUE_BITS - 1));

    // The partial remainder stays below the divisor, so it fits in RW bits.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[VALUE_BITS-1]};
        fits     = (shifted >= {1'b0, div_reg});
        rem_next = fits ? RW'(shifted - {1'b0, div_reg}) : shifted[RW-1:0];
        quo_next = {quo_reg[VALUE_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (last)
                    busy_reg <= 1'b0;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= ctrl.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> hw/rtl/multiplexed_seven_segment_driver.sv
// Multiplexed seven-segment display driver, top level: sequencer, digit
// store, APB register file and output register. Depends on msd_pkg, msd_if, msd_div.
//
// Each transfer on value_ch is one scan tick and yields exactly one transfer on
// disp_ch, giving the segments for one display position. When the number
// differs from the one last split (or after reset), it is split into digits by
// repeated division in a bit-serial divider, one division per digit; a zero
// yields no digits. An unchanged number is shown from the stored digits
// without a new split, and the result of every tick is registered in the
// output register. The block takes one tick at a time; a result waiting in
// the output register does not hold up the next tick until that tick's own
// result is ready. A new radix takes effect at the next digit division; a new
// position count bounds the digits of the next split and sets the scan range
// at once; alignment and leading-zero settings act at once.
`default_nettype none

module multiplexed_seven_segment_driver #(
    parameter int MAX_POSITIONS = msd_pkg::MAX_POSITIONS_DEF,
    parameter int VALUE_BITS    = msd_pkg::VALUE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    msd_value_if.sink                          value_ch,
    msd_disp_if.source                         disp_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [msd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [msd_pkg::PDATA_W-1:0]   pwdata,
    output logic      [msd_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    localparam int CNT_W = $clog2(MAX_POSITIONS + 1);
    localparam int IDX_W = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int RW    = msd_pkg::RADIX_W;
    localparam int PW    = msd_pkg::POS_W;
    localparam int DW    = msd_pkg::DIGIT_W;
    localparam int SW    = msd_pkg::SEG_W;

    // Configuration registers.
    logic [RW-1:0]     radix_reg;
    logic [PW-1:0]     positions_reg;
    logic              right_reg;
    logic              zeroes_reg;
    msd_pkg::reg_idx_t reg_sel;
    logic              cfg_write;

    // Sequencer and display state.
    msd_pkg::state_t       state_reg, state_next;
    logic [VALUE_BITS-1:0] cached_value_reg;
    logic                  cache_valid_reg;
    logic [CNT_W-1:0]      digits_found_reg;
    logic [CNT_W-1:0]      n_split_reg;
    logic [CNT_W-1:0]      scan_reg;
    logic [DW-1:0]         digit_store [MAX_POSITIONS];
    logic                  out_valid_reg;
    logic [SW-1:0]         seg_reg;
    logic [msd_pkg::SCAN_W-1:0] pos_reg;

    // Divider connections.
    msd_pkg::div_ctrl_t    div_ctrl;
    logic [VALUE_BITS-1:0] div_dividend;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [RW-1:0]         div_remainder;

    // Sequencer outputs.
    logic accepted;
    logic split_needed;
    logic more_digits;
    logic store_we;
    logic out_load;

    // Effective settings and display lookup.
    logic [RW-1:0]    radix_eff;
    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] scan_eff;
    logic [CNT_W-1:0] k_right;
    logic [CNT_W-1:0] k_left;
    logic [IDX_W-1:0] rd_idx;
    logic             show_digit;
    logic [SW-1:0]    seg_value;

    // ---------------------------------------------------------------- APB
    assign pready    = 1'b1;
    assign reg_sel   = msd_pkg::reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= msd_pkg::RADIX_RST;
            positions_reg <= msd_pkg::POSITIONS_RST;
            right_reg     <= msd_pkg::RIGHT_RST;
            zeroes_reg    <= msd_pkg::ZEROES_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                msd_pkg::REG_RADIX:          radix_reg     <= pwdata[RW-1:0];
                msd_pkg::REG_POSITIONS_USED: positions_reg <= pwdata[PW-1:0];
                msd_pkg::REG_RIGHT_ALIGNED:  right_reg     <= pwdata[0];
                msd_pkg::REG_SHOW_ZEROES:    zeroes_reg    <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            msd_pkg::REG_RADIX:          prdata = msd_pkg::PDATA_W'(radix_reg);
            msd_pkg::REG_POSITIONS_USED: prdata = msd_pkg::PDATA_W'(positions_reg);
            msd_pkg::REG_RIGHT_ALIGNED:  prdata = msd_pkg::PDATA_W'(right_reg);
            msd_pkg::REG_SHOW_ZEROES:    prdata = msd_pkg::PDATA_W'(zeroes_reg);
        endcase
    end

    // ------------------------------------------------------ effective settings
    always_comb
    begin
        priority if (radix_reg < msd_pkg::RADIX_MIN)
            radix_eff = msd_pkg::RADIX_MIN;
        else if (radix_reg > msd_pkg::RADIX_MAX)
            radix_eff = msd_pkg::RADIX_MAX;
        else
            radix_eff = radix_reg;

        priority if (positions_reg == '0)
            n_eff = CNT_W'(1);
        else if ({1'b0, positions_reg} > (PW + 1)'(MAX_POSITIONS))
            n_eff = CNT_W'(MAX_POSITIONS);
        else
            n_eff = CNT_W'(positions_reg);
    end

    // ------------------------------------------------------------- divider
    assign div_dividend = (state_reg == msd_pkg::ST_IDLE) ? value_ch.value : div_quotient;

    msd_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // ----------------------------------------------------------- sequencer
    assign split_needed = !cache_valid_reg || (value_ch.value != cached_value_reg);
    assign more_digits  = (div_quotient != '0)
                       && (({1'b0, digits_found_reg} + 1'b1) < {1'b0, n_split_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= msd_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        accepted         = 1'b0;
        store_we         = 1'b0;
        out_load         = 1'b0;
        div_ctrl.start   = 1'b0;
        div_ctrl.divisor = radix_eff;
        unique case (state_reg)
            msd_pkg::ST_IDLE:
            begin
                accepted = value_ch.valid;
                if (value_ch.valid)
                begin
                    if (split_needed && (value_ch.value != '0))
                    begin
                        div_ctrl.start = 1'b1;
                        state_next     = msd_pkg::ST_SPLIT;
                    end
                    else
                        state_next = msd_pkg::ST_SHOW;
                end
            end
            msd_pkg::ST_SPLIT:
            begin
                if (div_done)
                begin
                    store_we = 1'b1;
                    if (more_digits)
                        div_ctrl.start = 1'b1;
                    else
                        state_next = msd_pkg::ST_SHOW;
                end
            end
            msd_pkg::ST_SHOW:
            begin
                if (!out_valid_reg || disp_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = msd_pkg::ST_IDLE;
                end
            end
            default:
                state_next = msd_pkg::ST_IDLE;
        endcase
    end

    assign value_ch.ready = (state_reg == msd_pkg::ST_IDLE);

    // ------------------------------------------------------- display lookup
    always_comb
    begin
        scan_eff = (scan_reg >= n_eff) ? '0 : scan_reg;
        k_right  = n_eff - scan_eff - 1'b1;
        k_left   = digits_found_reg - scan_eff - 1'b1;
        if (right_reg)
        begin
            show_digit = (k_right < digits_found_reg);
            rd_idx     = k_right[IDX_W-1:0];
        end
        else
        begin
            show_digit = (scan_eff < digits_found_reg);
            rd_idx     = k_left[IDX_W-1:0];
        end
        // Positions without a digit are blank, or zero when right aligned
        // with leading zeroes enabled.
        if (show_digit)
            seg_value = msd_pkg::seg_decode(digit_store[rd_idx]);
        else if (right_reg && zeroes_reg)
            seg_value = msd_pkg::seg_decode('0);
        else
            seg_value = '0;
    end

    // ------------------------------------------------------------ datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cached_value_reg <= '0;
            cache_valid_reg  <= 1'b0;
            digits_found_reg <= '0;
            n_split_reg      <= '0;
            scan_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accepted && split_needed)
            begin
                cached_value_reg <= value_ch.value;
                cache_valid_reg  <= 1'b1;
                digits_found_reg <= '0;
                n_split_reg      <= n_eff;
            end
            else if (store_we)
                digits_found_reg <= digits_found_reg + 1'b1;

            if (out_load)
            begin
                scan_reg      <= scan_eff + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (disp_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            digit_store[digits_found_reg[IDX_W-1:0]] <= div_remainder[DW-1:0];
        if (out_load)
        begin
            seg_reg <= seg_value;
            pos_reg <= scan_eff[msd_pkg::SCAN_W-1:0];
        end
    end

    assign disp_ch.valid    = out_valid_reg;
    assign disp_ch.segments = seg_reg;
    assign disp_ch.position = pos_reg;

    // ----------------------------------------------------------- assertions
    a_digits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == msd_pkg::ST_SHOW) |-> (digits_found_reg <= n_split_reg))
        else $error("more digits stored than the split allowed");

    a_done_in_split: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == msd_pkg::ST_SPLIT))
        else $error("divider finished outside a split");

    a_cache_update: assert property (@(posedge clk) disable iff (!rst_n)
        (accepted && split_needed)
        |=> (cache_valid_reg && (cached_value_reg == $past(value_ch.value))))
        else $error("cache not updated after a split");

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg <= CNT_W'(MAX_POSITIONS))
        else $error("scan index beyond the position count");

endmodule

`default_nettype wire
